### hdl/fqd_pkg.sv
package fqd_pkg;

  // Port widths fixed by the item format
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // Default sizing
  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_DEL = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

endpackage

### hdl/fqd_ram.sv
module fqd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fifo_queue_with_delete.sv
// FIFO queue of nonzero handles kept as a linked list in a slot store.
// Input channel (in_valid_i/in_ready_o): one beat carries action_i (enqueue,
// dequeue, delete first match) and handle_in_i. Output channel
// (out_valid_o/out_ready_i): one beat per input beat with status_o,
// handle_out_o (dequeued handle, else zero) and count_o (handles queued after
// the operation), in input order.
// Each result passes through S_RESP: a rejected or ignored operation goes
// there directly; enqueue and dequeue read at accept and write back in
// S_ENQ or S_DEQ; a delete walks the list (S_WALK), bypasses a matched node
// at its predecessor (S_LINK, skipped for the head), frees it (S_FREE), and
// a miss ends at the tail. The delete walk reads one node per cycle through
// the registered read port of the handle and link memories. No new beat is
// taken while an operation is still in work; a new beat is accepted in the
// cycle its predecessor's result moves into the output register.
// Stall: the output register holds its beat until taken; one more input beat
// is accepted and worked off, then the block waits with in_ready_o low.
// Reset clears the list (empty queue, no slots used); slot memories are not
// cleared, fresh slots are handed out in order behind a free list.
module fifo_queue_with_delete #(
  parameter int unsigned SLOTS       = fqd_pkg::SLOTS_DEF,
  parameter int unsigned HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fqd_pkg::ACTION_W-1:0]  action_i,
  input  logic [fqd_pkg::HANDLE_W-1:0]  handle_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fqd_pkg::STATUS_W-1:0]  status_o,
  output logic [fqd_pkg::HANDLE_W-1:0]  handle_out_o,
  output logic [fqd_pkg::COUNT_W-1:0]   count_o
);

  import fqd_pkg::*;

  // stored handle width: only the low HANDLE_BITS of the port are significant
  localparam int unsigned HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,   // write-back of an enqueue
    S_DEQ,   // write-back of a dequeue
    S_WALK,  // delete search, one node per cycle
    S_LINK,  // bypass the deleted node at its predecessor
    S_FREE,  // push the deleted node onto the free list
    S_RESP   // result waits for the output register
  } state_e;

  state_e          state_q;
  logic [IW-1:0]   head_q, tail_q;
  logic [CW-1:0]   count_q;
  // freed slots are chained through the link memory
  logic [IW-1:0]   free_head_q;
  logic [CW-1:0]   free_cnt_q;

  logic [HW-1:0]   op_h_q;
  logic [IW-1:0]   cur_q, prev_q, nxt_q;
  logic [CW-1:0]   idx_q;
  status_e         res_status_q;
  logic [HW-1:0]   res_handle_q;

  logic            out_valid_q;
  status_e         out_status_q;
  logic [HW-1:0]   out_handle_q;
  logic [CW+4:0]   out_count_q;

  // memory ports
  logic            hram_we, hram_re, lram_we, lram_re;
  logic [IW-1:0]   hram_waddr, lram_waddr, mem_raddr;
  logic [HW-1:0]   hram_wdata, hram_rdata;
  logic [IW-1:0]   lram_wdata, lram_rdata;

  logic            accept, out_free, walk_hit, walk_last;
  logic [HW-1:0]   h_in;
  logic [IW-1:0]   alloc_slot;
  state_e          dec_state;
  status_e         dec_status;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_RESP) && out_free);
  assign accept     = in_valid_i && in_ready_o;
  assign h_in       = handle_in_i[HW-1:0];

  // with no freed slot the next fresh one sits at index count (count < SLOTS)
  assign alloc_slot = (free_cnt_q != '0) ? free_head_q : count_q[IW-1:0];

  assign walk_hit  = (hram_rdata == op_h_q);
  assign walk_last = ((idx_q + CW'(1)) == count_q);

  // Decode of an incoming beat: early rejects and the unused action go straight to the result
  always_comb begin
    dec_state  = S_RESP;
    dec_status = ST_OK;
    case (action_i)
      ACT_ENQ: begin
        if (h_in == '0) begin
          dec_status = ST_NULL;
        end else if (count_q == CW'(SLOTS)) begin
          dec_status = ST_FULL;
        end else begin
          dec_state = S_ENQ;
        end
      end
      ACT_DEQ: begin
        if (count_q == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_state = S_DEQ;
        end
      end
      ACT_DEL: begin
        if (h_in == '0) begin
          dec_status = ST_NULL;
        end else if (count_q == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_state = S_WALK;
        end
      end
      default: begin
        dec_status = ST_OK;  // unused action: no effect
      end
    endcase
  end

  // Memory access control. Reads are issued at accept or during the walk,
  // writes only in write-back states, so no cycle reads and writes at once.
  always_comb begin
    hram_we    = 1'b0;
    hram_waddr = cur_q;
    hram_wdata = op_h_q;
    lram_we    = 1'b0;
    lram_waddr = cur_q;
    lram_wdata = free_head_q;
    hram_re    = 1'b0;
    lram_re    = 1'b0;
    mem_raddr  = head_q;
    if (accept) begin
      case (action_i)
        ACT_ENQ: begin
          lram_re   = 1'b1;        // next free slot behind the free head
          mem_raddr = free_head_q;
        end
        ACT_DEQ, ACT_DEL: begin
          hram_re   = 1'b1;
          lram_re   = 1'b1;
          mem_raddr = head_q;
        end
        default: begin
          mem_raddr = head_q;
        end
      endcase
    end else begin
      case (state_q)
        S_ENQ: begin
          hram_we    = 1'b1;
          lram_we    = (count_q != '0);
          lram_waddr = tail_q;
          lram_wdata = cur_q;
        end
        S_DEQ: begin
          lram_we    = 1'b1;
          lram_waddr = head_q;
          lram_wdata = free_head_q;
        end
        S_WALK: begin
          if (!walk_hit && !walk_last) begin
            hram_re   = 1'b1;
            lram_re   = 1'b1;
            mem_raddr = lram_rdata;
          end
        end
        S_LINK: begin
          lram_we    = 1'b1;
          lram_waddr = prev_q;
          lram_wdata = nxt_q;
        end
        S_FREE: begin
          lram_we    = 1'b1;
          lram_waddr = cur_q;
          lram_wdata = free_head_q;
        end
        default: begin
          hram_we = 1'b0;
        end
      endcase
    end
  end

  fqd_ram #(
    .WIDTH (HW),
    .DEPTH (SLOTS)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (hram_we),
    .waddr_i (hram_waddr),
    .wdata_i (hram_wdata),
    .re_i    (hram_re),
    .raddr_i (mem_raddr),
    .rdata_o (hram_rdata)
  );

  fqd_ram #(
    .WIDTH (IW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lram_we),
    .waddr_i (lram_waddr),
    .wdata_i (lram_wdata),
    .re_i    (lram_re),
    .raddr_i (mem_raddr),
    .rdata_o (lram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      free_head_q  <= '0;
      free_cnt_q   <= '0;
      op_h_q       <= '0;
      cur_q        <= '0;
      prev_q       <= '0;
      nxt_q        <= '0;
      idx_q        <= '0;
      res_status_q <= ST_OK;
      res_handle_q <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_handle_q <= '0;
      out_count_q  <= '0;
    end else begin
      // count_q already reflects the finished operation here
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_handle_q <= res_handle_q;
        out_count_q  <= (CW+5)'(count_q);
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (accept) begin
        state_q      <= dec_state;
        res_status_q <= dec_status;
        res_handle_q <= '0;
        op_h_q       <= h_in;
        cur_q        <= (action_i == ACT_ENQ) ? alloc_slot : head_q;
        idx_q        <= '0;
      end else begin
        case (state_q)
          S_ENQ: begin
            if (count_q == '0) begin
              head_q <= cur_q;
            end
            tail_q  <= cur_q;
            count_q <= count_q + CW'(1);
            if (free_cnt_q != '0) begin
              free_head_q <= lram_rdata;
              free_cnt_q  <= free_cnt_q - CW'(1);
            end
            state_q <= S_RESP;
          end
          S_DEQ: begin
            res_handle_q <= hram_rdata;
            if (count_q != CW'(1)) begin
              head_q <= lram_rdata;
            end
            count_q     <= count_q - CW'(1);
            free_head_q <= head_q;
            free_cnt_q  <= free_cnt_q + CW'(1);
            state_q     <= S_RESP;
          end
          S_WALK: begin
            if (walk_hit) begin
              nxt_q <= lram_rdata;
              if (walk_last) begin
                tail_q <= prev_q;
              end
              if (idx_q == '0) begin
                head_q  <= lram_rdata;
                state_q <= S_FREE;
              end else begin
                state_q <= S_LINK;
              end
            end else if (walk_last) begin
              res_status_q <= ST_MISSING;
              state_q      <= S_RESP;
            end else begin
              prev_q <= cur_q;
              cur_q  <= lram_rdata;
              idx_q  <= idx_q + CW'(1);
            end
          end
          S_LINK: begin
            state_q <= S_FREE;
          end
          S_FREE: begin
            free_head_q <= cur_q;
            free_cnt_q  <= free_cnt_q + CW'(1);
            count_q     <= count_q - CW'(1);
            state_q     <= S_RESP;
          end
          S_RESP: begin
            if (out_free) begin
              state_q <= S_IDLE;
            end
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign handle_out_o = HANDLE_W'(out_handle_q);
  assign count_o      = out_count_q[COUNT_W-1:0];

  // queued plus freed slots never exceed the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CW+1)'(count_q) + (CW+1)'(free_cnt_q)) <= (CW+1)'(SLOTS))
    else $error("slot accounting exceeds store size");

  // the search never runs past the end of the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (idx_q < count_q))
    else $error("delete walk beyond list length");

  // a dequeued slot always holds a nonzero handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEQ) |-> (hram_rdata != '0))
    else $error("dequeue read a null handle");

  // a result beat only comes out of the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("output loaded outside result state");

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fqd_pkg::*;

  // Action code 3 has no meaning in the block: it must be ignored.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned QUEUE_SLOTS = SLOTS_DEF;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int LONG_HOLD = 80;

  // One result beat as the block should report it.
  typedef struct {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  count;
  } queue_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i = ACT_ENQ;
  logic [HANDLE_W-1:0] handle_in_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [HANDLE_W-1:0] handle_out_o;
  logic [COUNT_W-1:0]  count_o;

  // Predictor state: the queue contents in list order. Slot numbers are not
  // visible at the ports, so order and multiplicity are all that matter.
  logic [HANDLE_W-1:0] queued_handles[$];
  queue_result_t       results_due[$];
  queue_result_t       next_due;

  int  mismatches = 0;
  int  beats_sent = 0;
  int  beats_checked = 0;
  int  peak_depth = 0;
  int  status_seen[5] = '{default: 0};
  bit  idle_on = 1'b1;
  bit  long_hold_req = 1'b0;
  int  stall_left = 0;

  fifo_queue_with_delete dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .handle_in_i (handle_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .handle_out_o(handle_out_o),
    .count_o     (count_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Apply one operation to the predicted queue and return the result beat.
  // Null handle is checked before emptiness on delete; a full store only
  // matters for a nonzero enqueue; action 3 changes nothing.
  function automatic queue_result_t apply_queue_op(input logic [ACTION_W-1:0] act,
                                                   input logic [HANDLE_W-1:0] h);
    queue_result_t res;
    int            hit;
    res.status = ST_OK;
    res.handle = '0;
    hit = -1;
    case (act)
      ACT_ENQ: begin
        if (h == '0) res.status = ST_NULL;
        else if (queued_handles.size() >= QUEUE_SLOTS) res.status = ST_FULL;
        else queued_handles.push_back(h);
      end
      ACT_DEQ: begin
        if (queued_handles.size() == 0) res.status = ST_EMPTY;
        else res.handle = queued_handles.pop_front();
      end
      ACT_DEL: begin
        if (h == '0) begin
          res.status = ST_NULL;
        end else if (queued_handles.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // first match walking from the head
          for (int i = 0; i < queued_handles.size(); i++) begin
            if (hit < 0 && queued_handles[i] == h) hit = i;
          end
          if (hit < 0) res.status = ST_MISSING;
          else queued_handles.delete(hit);
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(queued_handles.size());
    if (queued_handles.size() > peak_depth) peak_depth = queued_handles.size();
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
                                 input logic [HANDLE_W-1:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (beat %0d, %0t)",
             what, got, want, beats_checked, $realtime);
    mismatches++;
  endtask

  // Drive one input beat at the falling edge, hold it until accepted, then
  // maybe leave valid low for a short burst.
  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [HANDLE_W-1:0] h);
    int gap;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    action_i    <= act;
    handle_in_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    results_due.push_back(apply_queue_op(act, h));
    beats_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Sender pauses: valid down, then wait until every result is back.
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: random short stalls, or one long hold-off on request.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_ready_i <= 1'b0;
      stall_left = LONG_HOLD - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker: every accepted output beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_checked++;
      if (status_o < 5) status_seen[status_o]++;
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing pending", HANDLE_W'(status_o), '0);
      end else begin
        next_due = results_due.pop_front();
        if (status_o !== next_due.status)
          report_mismatch("status", HANDLE_W'(status_o), HANDLE_W'(next_due.status));
        if (handle_out_o !== next_due.handle)
          report_mismatch("handle_out", handle_out_o, next_due.handle);
        if (count_o !== next_due.count)
          report_mismatch("count", HANDLE_W'(count_o), HANDLE_W'(next_due.count));
      end
    end
  end

  // Rejects on an empty queue, ignored action, then head, tail, middle and
  // duplicate deletes on a short list.
  task automatic test_corner_cases();
    send_beat(ACT_ENQ, '0);               // null enqueue
    send_beat(ACT_DEQ, 32'hFFFF_FFFF);    // empty dequeue, handle ignored
    send_beat(ACT_DEL, '0);               // null wins over empty
    send_beat(ACT_DEL, 32'h0000_0005);    // empty delete
    send_beat(ACT_UNUSED, 32'hFFFF_FFFF);
    send_beat(ACT_ENQ, 32'hFFFF_FFFF);
    send_beat(ACT_ENQ, 32'h0000_0001);
    send_beat(ACT_ENQ, 32'h8000_0000);
    send_beat(ACT_ENQ, 32'h0000_0001);    // duplicate
    send_beat(ACT_DEL, 32'h0000_0002);    // not found
    send_beat(ACT_DEL, 32'hFFFF_FFFF);    // head match
    send_beat(ACT_DEL, 32'h0000_0001);    // head again, first of the pair
    send_beat(ACT_DEL, 32'h0000_0001);    // tail match
    send_beat(ACT_ENQ, 32'h0000_0007);
    send_beat(ACT_ENQ, 32'h0000_0009);
    send_beat(ACT_DEL, 32'h0000_0007);    // middle
    send_beat(ACT_DEQ, 32'h0000_0000);
    send_beat(ACT_UNUSED, 32'h0000_0003);
    pause_until_drained();
  endtask

  // Fill every slot, bounce off the full store, free one and refill it.
  task automatic test_full_store();
    while (queued_handles.size() < QUEUE_SLOTS) send_beat(ACT_ENQ, $urandom() | 32'h1);
    send_beat(ACT_ENQ, '0);               // null is checked before full
    send_beat(ACT_ENQ, 32'hAAAA_5555);    // full
    send_beat(ACT_DEL, queued_handles[QUEUE_SLOTS / 2]);
    send_beat(ACT_ENQ, 32'h5555_AAAA);    // reuses the freed slot
    send_beat(ACT_DEL, queued_handles[QUEUE_SLOTS - 1]);
    send_beat(ACT_DEQ, '0);
    pause_until_drained();
  endtask

  // Random operations; weights in percent, dequeue gets the rest up to 96,
  // the last 4 percent is the unused action.
  task automatic test_random_ops(input int n, input int enq_pct, input int del_pct);
    int                  roll;
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [HANDLE_W-1:0] h;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) act = ACT_ENQ;
      else if (roll < enq_pct + del_pct) act = ACT_DEL;
      else if (roll < 96) act = ACT_DEQ;
      else act = ACT_UNUSED;
      pick = $urandom_range(0, 9);
      if (pick == 0) h = '0;
      else if (pick <= 3) h = HANDLE_W'($urandom_range(1, 8));   // small pool, duplicates
      else if (pick <= 6 && act == ACT_DEL && queued_handles.size() != 0)
        h = queued_handles[$urandom_range(0, queued_handles.size() - 1)];
      else h = $urandom();
      send_beat(act, h);
    end
    pause_until_drained();
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the
  // block fills its output and stalls its input.
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    test_random_ops(30, 50, 30);
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_ops(200, 45, 25);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_corner_cases();
    test_full_store();
    test_random_ops(300, 60, 15);   // fill-heavy, hits full often
    test_random_ops(300, 25, 25);   // drain-heavy, hits empty often
    test_random_ops(300, 40, 30);   // balanced
    test_output_backpressure();
    test_back_to_back();

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Summary: %0d beats sent, %0d checked, peak depth %0d of %0d slots",
             beats_sent, beats_checked, peak_depth, QUEUE_SLOTS);
    $display("Statuses: ok %0d, null %0d, empty %0d, full %0d, not found %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
